### rtl/core/ising_spin_flip_energy_unit_defines.svh
// ----------------------------------------------------------------------------
// Ising spin flip energy unit - assertion macros
// Concurrent assertion wrappers shared by the RTL files of the unit.
// ----------------------------------------------------------------------------
`ifndef ISING_SPIN_FLIP_ENERGY_UNIT_DEFINES_SVH
`define ISING_SPIN_FLIP_ENERGY_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset only
`define ISFE_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
// checked on every edge, reset included
`define ISFE_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define ISFE_ASSERT(lbl, ck, rn, prop, msg)
`define ISFE_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

### rtl/core/isfe_pkg.sv
// ----------------------------------------------------------------------------
// isfe_pkg - shared types and constants
// Sizes, stream field layout and the command format passed front to back.
// ----------------------------------------------------------------------------
package isfe_pkg;

  // system size
  localparam int NUM_SPINS     = 16;
  localparam int SPIN_W        = $clog2(NUM_SPINS);
  localparam int MAX_EDGES     = 256;
  localparam int EDGE_W        = $clog2(MAX_EDGES);
  localparam int COUPLING_BITS = 16;
  localparam int CPL_FW        = 16;
  localparam int CPL_W         = (COUPLING_BITS < CPL_FW) ? COUPLING_BITS : CPL_FW;
  localparam int MAX_ROW       = 16;
  localparam int ROW_W         = $clog2(MAX_ROW + 1);

  // arithmetic widths
  localparam int ENERGY_W = 32;
  localparam int DELTA_W  = 21;
  localparam int SUM_W    = CPL_W + 2 + $clog2(MAX_ROW);

  localparam logic signed [DELTA_W-1:0] DELTA_MAXV = {1'b0, {(DELTA_W-1){1'b1}}};
  localparam logic signed [DELTA_W-1:0] DELTA_MINV = {1'b1, {(DELTA_W-1){1'b0}}};
  localparam logic signed [ENERGY_W-1:0] ENERGY_MAXV = {1'b0, {(ENERGY_W-1){1'b1}}};
  localparam logic signed [ENERGY_W-1:0] ENERGY_MINV = {1'b1, {(ENERGY_W-1){1'b0}}};

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // input beat layout
  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 80;
  localparam int IN_SPIN_LO  = 0;
  localparam int IN_EDGE_LO  = 4;
  localparam int IN_NB_LO    = 12;
  localparam int IN_CPL_LO   = 16;
  localparam int IN_RSTART_LO = 32;
  localparam int IN_RCNT_LO  = 40;
  localparam int IN_RCNT_FW  = 5;
  localparam int IN_ENERGY_LO = 45;

  // output beat layout
  localparam int OUT_USED_W  = ENERGY_W + DELTA_W + 1;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_FLIP   = 2'd0,
    OP_EDGE   = 2'd1,
    OP_ROW    = 2'd2,
    OP_ENERGY = 2'd3
  } op_t;

  typedef struct packed {
    op_t                         op;
    logic [SPIN_W-1:0]           spin;
    logic [EDGE_W-1:0]           edge_addr;
    logic [SPIN_W-1:0]           nb;
    logic signed [CPL_W-1:0]     cpl;
    logic [EDGE_W-1:0]           row_start;
    logic [ROW_W-1:0]            row_len;
    logic signed [ENERGY_W-1:0]  energy;
  } cmd_t;

endpackage

### rtl/core/isfe_front.sv
// ----------------------------------------------------------------------------
// isfe_front - input stage
// Takes input beats, decodes them into commands and pushes them to the queue.
// ----------------------------------------------------------------------------
module isfe_front import isfe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // spin_index, edge_index, neighbor_index, coupling, row_start, row_count,
  // energy_value, zero pad
  input  logic [IN_TDATA_W-1:0] in_tdata,
  // op
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  push,
  output cmd_t                  push_data,
  input  logic                  full
);

  logic       vld_r;
  cmd_t       cmd_r;
  logic       take;
  cmd_t       dec;
  logic [IN_RCNT_FW-1:0] rcnt;

  // field decode, row length clamped to the longest walk
  always_comb begin
    rcnt              = in_tdata[IN_RCNT_LO +: IN_RCNT_FW];
    dec.op            = op_t'(in_tuser);
    dec.spin          = in_tdata[IN_SPIN_LO +: SPIN_W];
    dec.edge_addr     = in_tdata[IN_EDGE_LO +: EDGE_W];
    dec.nb            = in_tdata[IN_NB_LO +: SPIN_W];
    dec.cpl           = $signed(in_tdata[IN_CPL_LO +: CPL_W]);
    dec.row_start     = in_tdata[IN_RSTART_LO +: EDGE_W];
    dec.energy        = $signed(in_tdata[IN_ENERGY_LO +: ENERGY_W]);
    if (rcnt > IN_RCNT_FW'(MAX_ROW)) begin
      dec.row_len = ROW_W'(MAX_ROW);
    end else begin
      dec.row_len = ROW_W'(rcnt);
    end
  end

  assign push      = vld_r && !full;
  assign in_tready = !vld_r || !full;
  assign take      = in_tvalid && in_tready;
  assign push_data = cmd_r;

  // one command register in front of the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (push) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= dec;
    end
  end

endmodule

### rtl/core/isfe_fifo.sv
// ----------------------------------------------------------------------------
// isfe_fifo - command queue
// Short queue that decouples the input stage from the execution stage.
// ----------------------------------------------------------------------------
`include "ising_spin_flip_energy_unit_defines.svh"

module isfe_fifo import isfe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic not_empty
);

  cmd_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  assign full      = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  `ISFE_ASSERT(a_fifo_no_ovf, clk, rst_n, !(push && full), "isfe_fifo: push while full")
  `ISFE_ASSERT(a_fifo_no_udf, clk, rst_n, !(pop && !not_empty), "isfe_fifo: pop while empty")
  `ISFE_ASSERT(a_fifo_level, clk, rst_n, (push && !pop) |=> count_r == $past(count_r) + 1'b1, "isfe_fifo: level lost a push")

endmodule

### rtl/core/isfe_back.sv
// ----------------------------------------------------------------------------
// isfe_back - execution stage
// Holds spins, row and edge tables and the energy; walks neighbour lists.
// ----------------------------------------------------------------------------
`include "ising_spin_flip_energy_unit_defines.svh"

module isfe_back import isfe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   head,
  input  logic                   not_empty,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // energy, delta_energy, new_spin, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_SAT,
    S_ADD,
    S_DONE
  } state_t;

  state_t                     state_r;
  logic [NUM_SPINS-1:0]       spin_sign_r;
  logic [EDGE_W-1:0]          row_first_r [NUM_SPINS];
  logic [ROW_W-1:0]           row_len_r   [NUM_SPINS];
  logic signed [ENERGY_W-1:0] energy_r;
  logic                       s_self_r;
  logic                       new_spin_r;
  logic [EDGE_W-1:0]          first_r;
  logic [ROW_W-1:0]           len_r;
  logic [ROW_W-1:0]           issue_cnt_r;
  logic                       rd_vld_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [DELTA_W-1:0]  delta_r;
  logic                       res_vld_r;
  logic signed [ENERGY_W-1:0] res_energy_r;
  logic signed [DELTA_W-1:0]  res_delta_r;
  logic                       res_new_r;

  // edge table: neighbour index over coupling
  logic [SPIN_W+CPL_W-1:0]    edge_mem [MAX_EDGES];
  logic [SPIN_W+CPL_W-1:0]    rd_data_r;
  logic [EDGE_W-1:0]          rd_addr;
  logic                       edge_we;

  logic                       issue;
  logic                       out_take;
  logic                       res_load;
  logic [SPIN_W-1:0]          rd_nb;
  logic signed [CPL_W-1:0]    rd_cpl;
  logic [SPIN_W-1:0]          sign_addr;
  logic                       sign_rd;
  logic signed [SUM_W-1:0]    twice_j;
  logic signed [SUM_W-1:0]    term;
  logic signed [ENERGY_W:0]   esum;

  assign pop      = (state_r == S_IDLE) && not_empty;
  assign edge_we  = pop && (head.op == OP_EDGE);
  assign issue    = (state_r == S_WALK) && (issue_cnt_r < len_r);
  assign rd_addr  = first_r + EDGE_W'(issue_cnt_r);
  assign out_take = res_vld_r && out_tready;
  assign res_load = (state_r == S_DONE) && (!res_vld_r || out_tready);

  // one sign read port: flipped spin at dispatch, neighbour during the walk
  assign rd_nb     = rd_data_r[SPIN_W+CPL_W-1:CPL_W];
  assign rd_cpl    = $signed(rd_data_r[CPL_W-1:0]);
  assign sign_addr = (state_r == S_WALK) ? rd_nb : head.spin;
  assign sign_rd   = spin_sign_r[sign_addr];

  // +-2J, sign from the product of both spins
  assign twice_j = SUM_W'(rd_cpl) <<< 1;
  assign term    = (sign_rd ^ s_self_r) ? -twice_j : twice_j;

  // energy update, one guard bit for saturation
  assign esum = (ENERGY_W+1)'(energy_r) + (ENERGY_W+1)'(delta_r);

  // edge table write and registered read
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[head.edge_addr] <= {head.nb, head.cpl};
    end
    rd_data_r <= edge_mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      spin_sign_r <= '0;
      energy_r    <= '0;
      rd_vld_r    <= 1'b0;
      res_vld_r   <= 1'b0;
      issue_cnt_r <= '0;
    end else begin
      rd_vld_r <= issue;
      if (res_load) begin
        res_vld_r <= 1'b1;
      end else if (out_take) begin
        res_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            delta_r    <= '0;
            new_spin_r <= (head.op == OP_FLIP) && !sign_rd;
            state_r    <= (head.op == OP_FLIP) ? S_WALK : S_DONE;
            case (head.op)
              OP_FLIP: begin
                spin_sign_r[head.spin] <= ~sign_rd;
                s_self_r    <= ~sign_rd;
                first_r     <= row_first_r[head.spin];
                len_r       <= row_len_r[head.spin];
                issue_cnt_r <= '0;
                sum_r       <= '0;
              end
              OP_ROW: begin
                row_first_r[head.spin] <= head.row_start;
                row_len_r[head.spin]   <= head.row_len;
              end
              OP_ENERGY: begin
                energy_r <= head.energy;
              end
              default: begin
                // edge writes go through the table port
              end
            endcase
          end
        end
        S_WALK: begin
          if (issue) begin
            issue_cnt_r <= issue_cnt_r + 1'b1;
          end
          if (rd_vld_r) begin
            sum_r <= sum_r + term;
          end
          if (!issue && !rd_vld_r) begin
            state_r <= S_SAT;
          end
        end
        S_SAT: begin
          if (sum_r > SUM_W'(DELTA_MAXV)) begin
            delta_r <= DELTA_MAXV;
          end else if (sum_r < SUM_W'(DELTA_MINV)) begin
            delta_r <= DELTA_MINV;
          end else begin
            delta_r <= sum_r[DELTA_W-1:0];
          end
          state_r <= S_ADD;
        end
        S_ADD: begin
          if (esum[ENERGY_W] != esum[ENERGY_W-1]) begin
            energy_r <= esum[ENERGY_W] ? ENERGY_MINV : ENERGY_MAXV;
          end else begin
            energy_r <= esum[ENERGY_W-1:0];
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            res_energy_r <= energy_r;
            res_delta_r  <= delta_r;
            res_new_r    <= new_spin_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, res_new_r, res_delta_r, res_energy_r};

  `ISFE_ASSERT_ALWAYS(a_back_rst, clk, !rst_n |=> (state_r == S_IDLE && !res_vld_r), "isfe_back: not idle after reset")
  `ISFE_ASSERT(a_back_cnt, clk, rst_n, (state_r == S_WALK) |-> issue_cnt_r <= len_r, "isfe_back: walk ran past row")
  `ISFE_ASSERT(a_back_load, clk, rst_n, (pop && head.op != OP_FLIP) |=> (state_r == S_DONE && delta_r == '0), "isfe_back: load item with nonzero delta")
  `ISFE_ASSERT(a_back_hold, clk, rst_n, (res_vld_r && !out_tready) |=> $stable(res_energy_r) && $stable(res_delta_r), "isfe_back: result overwritten")

endmodule

### rtl/core/ising_spin_flip_energy_unit.sv
// Flow: a flip is dispatched, walks its row (at most 16 entries), drains the last
// edge read, saturates the delta, adds it to the energy and loads the result; a
// load item goes from dispatch straight to result load. The walk reads one
// neighbour per cycle from the single edge table read port; the execution stage
// takes the next command once its result is loaded, and the queue takes beats meanwhile.
// Reset: synchronous active low rst_n; spins to +1, energy to 0, queue empty;
// edge and row tables keep their contents and must be written before use.
// ----------------------------------------------------------------------------
// ising_spin_flip_energy_unit - top level
// Spin flip energy tracker: input stage, command queue and execution stage.
// ----------------------------------------------------------------------------
module ising_spin_flip_energy_unit import isfe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // spin_index[3:0], edge_index[11:4], neighbor_index[15:12], coupling[31:16],
  // row_start[39:32], row_count[44:40], energy_value[76:45], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [OP_W-1:0]        in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // energy[31:0], delta_energy[52:32], new_spin[53], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic push;
  cmd_t push_data;
  logic full;
  logic pop;
  cmd_t head;
  logic not_empty;

  // decode beats into commands
  isfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // decoupling queue
  isfe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  // execute and return results
  isfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .not_empty  (not_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### verif/isfe_energy_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isfe_energy_checker - result checker for the spin flip energy unit
// Watches both stream ports and keeps its own copy of the spin signs,
// neighbour lists and running energy. For every input beat it works out the
// energy report, queues it, and compares every output beat with the oldest
// queued report, field by field.
// ----------------------------------------------------------------------------
module isfe_energy_checker import isfe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]        in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     error_count,
  output int                     pending_count,
  output int                     checked_count,
  output int                     clip_count
);

  typedef struct packed {
    logic signed [ENERGY_W-1:0] energy;
    logic signed [DELTA_W-1:0]  delta;
    logic                       new_spin;
  } energy_report_t;

  // shadow state of the unit
  logic                       spin_neg [NUM_SPINS];
  logic [SPIN_W-1:0]          nb_mem   [MAX_EDGES];
  logic signed [CPL_W-1:0]    cpl_mem  [MAX_EDGES];
  logic [EDGE_W-1:0]          row_base [NUM_SPINS];
  logic [IN_RCNT_FW-1:0]      row_len  [NUM_SPINS];
  logic signed [ENERGY_W-1:0] energy_acc;

  energy_report_t report_q [$];
  int errors;
  int checked;
  int clips;

  // apply one input beat to the shadow state, return the report it yields
  function automatic energy_report_t apply_beat(op_t op, logic [IN_TDATA_W-1:0] d);
    logic [SPIN_W-1:0] s;
    logic [EDGE_W-1:0] e;
    int                walk;
    longint            sum;
    longint            term;
    longint            total;
    energy_report_t    r;
    r = '0;
    s = d[IN_SPIN_LO +: SPIN_W];
    case (op)
      OP_FLIP: begin
        spin_neg[s] = ~spin_neg[s];
        walk = (row_len[s] > MAX_ROW) ? MAX_ROW : int'(row_len[s]);
        sum = 0;
        // walk the list, wrapping past the last edge entry
        for (int k = 0; k < walk; k++) begin
          e = EDGE_W'(row_base[s] + k);
          term = 2 * longint'(cpl_mem[e]);
          // self edge compares the new sign with itself: always +2J
          if (spin_neg[nb_mem[e]] != spin_neg[s]) term = -term;
          sum += term;
        end
        if (sum > longint'(DELTA_MAXV)) begin
          sum = longint'(DELTA_MAXV);
          clips++;
        end else if (sum < longint'(DELTA_MINV)) begin
          sum = longint'(DELTA_MINV);
          clips++;
        end
        total = longint'(energy_acc) + sum;
        if (total > longint'(ENERGY_MAXV)) begin
          total = longint'(ENERGY_MAXV);
          clips++;
        end else if (total < longint'(ENERGY_MINV)) begin
          total = longint'(ENERGY_MINV);
          clips++;
        end
        energy_acc = ENERGY_W'(total);
        r.delta    = DELTA_W'(sum);
        r.new_spin = spin_neg[s];
      end
      OP_EDGE: begin
        e = d[IN_EDGE_LO +: EDGE_W];
        nb_mem[e]  = d[IN_NB_LO +: SPIN_W];
        cpl_mem[e] = d[IN_CPL_LO +: CPL_W];
      end
      OP_ROW: begin
        row_base[s] = d[IN_RSTART_LO +: EDGE_W];
        row_len[s]  = d[IN_RCNT_LO +: IN_RCNT_FW];
      end
      default: begin
        energy_acc = d[IN_ENERGY_LO +: ENERGY_W];
      end
    endcase
    r.energy = energy_acc;
    return r;
  endfunction

  // sample both ports on the rising edge
  always @(posedge clk) begin
    energy_report_t exp_r;
    energy_report_t act_r;
    if (!rst_n) begin
      foreach (spin_neg[i]) spin_neg[i] = 1'b0;
      energy_acc = '0;
      report_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        report_q.push_back(apply_beat(op_t'(in_tuser), in_tdata));
      if (out_tvalid && out_tready) begin
        act_r.energy   = out_tdata[0 +: ENERGY_W];
        act_r.delta    = out_tdata[ENERGY_W +: DELTA_W];
        act_r.new_spin = out_tdata[ENERGY_W + DELTA_W];
        if (report_q.size() == 0) begin
          $display("%0t: unexpected result beat energy %0d delta %0d spin %0b",
                   $time, act_r.energy, act_r.delta, act_r.new_spin);
          errors++;
        end else begin
          exp_r = report_q.pop_front();
          checked++;
          if (act_r.energy !== exp_r.energy) begin
            $display("%0t: energy expected %0d, actual %0d",
                     $time, exp_r.energy, act_r.energy);
            errors++;
          end
          if (act_r.delta !== exp_r.delta) begin
            $display("%0t: delta_energy expected %0d, actual %0d",
                     $time, exp_r.delta, act_r.delta);
            errors++;
          end
          if (act_r.new_spin !== exp_r.new_spin) begin
            $display("%0t: new_spin expected %0b, actual %0b",
                     $time, exp_r.new_spin, act_r.new_spin);
            errors++;
          end
        end
      end
    end
    error_count   <= errors;
    pending_count <= report_q.size();
    checked_count <= checked;
    clip_count    <= clips;
  end

  initial begin
    errors  = 0;
    checked = 0;
    clips   = 0;
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - top of the spin flip energy unit bench
// Drives directed then random beats (edge, row and energy loads, spin flips
// over legal neighbour lists) with varying idle patterns on both ports and
// one long output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import isfe_pkg::*;

  localparam int TOTAL_ITEMS  = 1550;
  localparam int LIMIT_CYCLES = 500000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 40;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int error_count;
  int pending_count;
  int checked_count;
  int clip_count;

  // idle pattern, set by the stimulus, used by both drivers
  int send_gap_pct;
  int recv_stall_pct;
  logic hold_off_req;
  logic hold_off_done;
  int hold_left;
  int cycle_count;

  // which table entries are loaded, so flips never read unwritten entries
  bit              edge_loaded [MAX_EDGES];
  bit              row_loaded  [NUM_SPINS];
  int              row_base_seen [NUM_SPINS];
  int              row_len_seen  [NUM_SPINS];
  int              items_sent;
  int              flips_sent;

  ising_spin_flip_energy_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  isfe_energy_checker u_energy_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .error_count   (error_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .clip_count    (clip_count)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // output side: random stalls plus one long hold-off on request
  initial begin
    out_tready    = 1'b0;
    hold_off_done = 1'b0;
    hold_left     = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_left     = HOLD_CYCLES;
        hold_off_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // one input beat: optional gap, then hold until accepted
  task automatic send_item(input op_t op, input int spin, input int edge_i, input int nb,
                           input int cpl, input int rstart, input int rcnt,
                           input int energy_v);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[IN_SPIN_LO +: SPIN_W]        = SPIN_W'(spin);
    d[IN_EDGE_LO +: EDGE_W]        = EDGE_W'(edge_i);
    d[IN_NB_LO +: SPIN_W]          = SPIN_W'(nb);
    d[IN_CPL_LO +: CPL_FW]         = CPL_FW'(cpl);
    d[IN_RSTART_LO +: EDGE_W]      = EDGE_W'(rstart);
    d[IN_RCNT_LO +: IN_RCNT_FW]    = IN_RCNT_FW'(rcnt);
    d[IN_ENERGY_LO +: ENERGY_W]    = ENERGY_W'(energy_v);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
    case (op)
      OP_FLIP: flips_sent++;
      OP_EDGE: edge_loaded[EDGE_W'(edge_i)] = 1'b1;
      OP_ROW: begin
        row_loaded[SPIN_W'(spin)]    = 1'b1;
        row_base_seen[SPIN_W'(spin)] = rstart & (MAX_EDGES - 1);
        row_len_seen[SPIN_W'(spin)]  = rcnt & ((1 << IN_RCNT_FW) - 1);
      end
      default: ;
    endcase
  endtask

  // a spin may flip only if its row and every edge it walks are loaded
  function automatic bit flip_ok(int s);
    int n;
    if (!row_loaded[s]) return 1'b0;
    n = (row_len_seen[s] > MAX_ROW) ? MAX_ROW : row_len_seen[s];
    for (int k = 0; k < n; k++)
      if (!edge_loaded[(row_base_seen[s] + k) % MAX_EDGES]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int find_flippable(int first);
    for (int i = 0; i < NUM_SPINS; i++)
      if (flip_ok((first + i) % NUM_SPINS)) return (first + i) % NUM_SPINS;
    return -1;
  endfunction

  function automatic int pick_coupling();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_energy();
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF - $urandom_range(0, 2000000);
      1:       return 32'h8000_0000 + $urandom_range(0, 2000000);
      2:       return $urandom();
      default: return $urandom_range(0, 4000000) - 2000000;
    endcase
  endfunction

  // load a neighbour list and the row pointing at it; heavy lists use one
  // extreme coupling towards one other spin, to drive the delta into clipping
  task automatic build_row(input int s, input bit heavy);
    int start;
    int cnt;
    int n;
    int nbv;
    int cv;
    int e;
    start = ($urandom_range(0, 3) == 0) ? $urandom_range(240, 255) : $urandom_range(0, 255);
    if (heavy)
      cnt = $urandom_range(0, 1) ? MAX_ROW : $urandom_range(17, 31);
    else
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 8);
    n   = (cnt > MAX_ROW) ? MAX_ROW : cnt;
    nbv = (s + $urandom_range(1, NUM_SPINS - 1)) % NUM_SPINS;
    cv  = $urandom_range(0, 1) ? -32768 : 32767;
    for (int k = 0; k < n; k++) begin
      e = (start + k) % MAX_EDGES;
      if (heavy)
        send_item(OP_EDGE, $urandom(), e, nbv, cv, $urandom(), $urandom(), $urandom());
      else if (!edge_loaded[e])
        send_item(OP_EDGE, $urandom(), e,
                  ($urandom_range(0, 5) == 0) ? s : $urandom_range(0, NUM_SPINS - 1),
                  pick_coupling(), $urandom(), $urandom(), $urandom());
    end
    send_item(OP_ROW, s, $urandom(), $urandom(), $urandom(), start, cnt, $urandom());
    if (heavy) begin
      send_item(OP_FLIP, s, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom());
      send_item(OP_FLIP, s, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom());
    end
  endtask

  // stimulus and verdict
  initial begin
    int rand_begin;
    int span;
    int r;
    int s;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = OP_FLIP;
    hold_off_req   = 1'b0;
    cycle_count    = 0;
    items_sent     = 0;
    flips_sent     = 0;
    send_gap_pct   = 20;
    recv_stall_pct = 56;
    foreach (edge_loaded[i]) edge_loaded[i] = 1'b0;
    foreach (row_loaded[i]) row_loaded[i] = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: wrapping list with a self edge, empty row, extreme energies
    send_item(OP_ENERGY, 0, 0, 0, 0, 0, 0, 32'h7FFF_FF00);
    send_item(OP_EDGE, 0, 254, 5, 32767, 0, 0, 0);
    send_item(OP_EDGE, 0, 255, 3, -32768, 0, 0, 0);
    send_item(OP_EDGE, 0, 0, 15, 1, 0, 0, 0);
    send_item(OP_EDGE, 0, 1, 0, -1, 0, 0, 0);
    send_item(OP_ROW, 5, 0, 0, 0, 254, 4, 0);
    send_item(OP_FLIP, 5, 0, 0, 0, 0, 0, 0);
    send_item(OP_FLIP, 5, 0, 0, 0, 0, 0, 0);
    send_item(OP_ROW, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_FLIP, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_ROW, 15, 0, 0, 0, 255, 2, 0);
    send_item(OP_FLIP, 15, 0, 0, 0, 0, 0, 0);
    send_item(OP_ENERGY, 0, 0, 0, 0, 0, 0, 32'h8000_0000);
    send_item(OP_FLIP, 5, 0, 0, 0, 0, 0, 0);
    send_item(OP_FLIP, 15, 0, 0, 0, 0, 0, 0);
    send_item(OP_ENERGY, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_FLIP, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_EDGE, 0, 2, 10, 16'h4000, 0, 0, 0);
    send_item(OP_ROW, 10, 0, 0, 0, 0, 3, 0);
    send_item(OP_FLIP, 10, 0, 0, 0, 0, 0, 0);
    send_item(OP_FLIP, 5, 0, 0, 0, 0, 0, 0);
    send_item(OP_ENERGY, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_item(OP_FLIP, 10, 0, 0, 0, 0, 0, 0);

    // random: three idle patterns, long output hold at the start of the last
    rand_begin = items_sent;
    span = (TOTAL_ITEMS - rand_begin) / 3;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= rand_begin + 2 * span) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_off_req  <= 1'b1;
      end else if (items_sent >= rand_begin + span) begin
        send_gap_pct   = 56;
        recv_stall_pct = 20;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        s = find_flippable($urandom_range(0, NUM_SPINS - 1));
        if (s >= 0)
          send_item(OP_FLIP, s, $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom());
        else
          build_row($urandom_range(0, NUM_SPINS - 1), 1'b0);
      end else if (r < 68) begin
        send_item(OP_EDGE, $urandom(), $urandom_range(0, MAX_EDGES - 1),
                  $urandom_range(0, NUM_SPINS - 1), pick_coupling(), $urandom(),
                  $urandom(), $urandom());
      end else if (r < 82) begin
        build_row($urandom_range(0, NUM_SPINS - 1), 1'b0);
      end else if (r < 87) begin
        build_row($urandom_range(0, NUM_SPINS - 1), 1'b1);
      end else if (r < 94) begin
        send_item(OP_ENERGY, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), pick_energy());
      end else begin
        // bare row write, possibly over unloaded edges: that spin rests a while
        send_item(OP_ROW, $urandom_range(0, NUM_SPINS - 1), $urandom(), $urandom(),
                  $urandom(), $urandom_range(0, MAX_EDGES - 1), $urandom_range(0, 31),
                  $urandom());
      end
    end
    in_tvalid <= 1'b0;

    // drain, then allow for the flip latency
    while (pending_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d beats, %0d of them spin flips; %0d results compared.",
             items_sent, flips_sent, checked_count);
    $display("Delta or energy clipped %0d times; %0d field errors.",
             clip_count, error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
